>>> hdl/mnpt_pkg.sv
// Shared constants and types for the MIDI note pair tracker.
package mnpt_pkg;

   // Event kinds carried on req_tuser
   localparam logic [1:0] KIND_NOTE_ON     = 2'd0;
   localparam logic [1:0] KIND_NOTE_OFF    = 2'd1;
   localparam logic [1:0] KIND_TRACK_START = 2'd2;

   // Field widths
   localparam int TRACK_W   = 16;
   localparam int CHAN_W    = 4;
   localparam int NOTE_W    = 7;
   localparam int VEL_W     = 7;
   localparam int TICK_W    = 31;
   localparam int ADDR_W    = CHAN_W + NOTE_W;
   localparam int DEPTH     = 1 << ADDR_W;
   localparam int EPOCH_W   = 8;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 96;

   // One active-note table entry
   typedef struct packed {
      logic               valid;
      logic [EPOCH_W-1:0] epoch;
      logic [VEL_W-1:0]   velocity;
      logic [TICK_W-1:0]  on_tick;
   } entry_type;

   // Table write request
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } wr_type;

endpackage

>>> hdl/mnpt_ram.sv
// Active-note table storage: one write port, one registered read port.
module mnpt_ram
   import mnpt_pkg::*;
(
   input  logic              clock,
   input  wr_type            wr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/midi_note_pair_tracker_core.sv
// Top level of the MIDI note pair tracker: pairs note-on and note-off words.
// A note-off word moves through the work stage into the result register, which shows
// its linked note. Throughput: one word per cycle unless stalled by the result or a
// clearing pass; the table read-modify-write forwards between back-to-back words on
// the same channel and note. Reset (synchronous, active high) starts a clearing pass
// over all 2048 entries with req_tready low; every 256th start-of-track runs it too.
module midi_note_pair_tracker_core
   import mnpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // track[15:0], channel[19:16], note[26:20], velocity[33:27], tick[64:34], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_track[15:0], out_channel[19:16], out_note[26:20], out_velocity[33:27],
   // on_tick[64:34], off_tick[95:65]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // input word fields
   logic [TRACK_W-1:0] req_track;
   logic [CHAN_W-1:0]  req_channel;
   logic [NOTE_W-1:0]  req_note;
   logic [VEL_W-1:0]   req_velocity;
   logic [TICK_W-1:0]  req_tick;
   logic [ADDR_W-1:0]  req_addr;
   logic               accept;

   assign req_track    = req_tdata[15:0];
   assign req_channel  = req_tdata[19:16];
   assign req_note     = req_tdata[26:20];
   assign req_velocity = req_tdata[33:27];
   assign req_tick     = req_tdata[64:34];
   assign req_addr     = {req_channel, req_note};
   assign accept       = req_tvalid && req_tready;

   // work stage registers
   logic               s1_valid_ff, s1_valid_in;
   logic [1:0]         s1_kind_ff;
   logic [TRACK_W-1:0] s1_track_ff;
   logic [CHAN_W-1:0]  s1_chan_ff;
   logic [NOTE_W-1:0]  s1_note_ff;
   logic [VEL_W-1:0]   s1_vel_ff;
   logic [TICK_W-1:0]  s1_tick_ff;
   logic               fwd_hit_ff, fwd_hit_in;
   entry_type          fwd_data_ff;

   // table epoch and clearing sweep
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               clr_ff, clr_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   entry_type ram_rd;
   entry_type s1_entry;
   wr_type    s1_wr;
   wr_type    ram_wr;
   logic      out_free, s1_go, s1_live, is_on, is_off, is_start, hit, wrap;
   logic [ADDR_W-1:0] s1_addr;

   mnpt_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd)
   );

   // lookup and update decisions
   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      s1_go    = s1_valid_ff && out_free;
      s1_entry = fwd_hit_ff ? fwd_data_ff : ram_rd;
      s1_live  = s1_entry.valid && (s1_entry.epoch == epoch_ff);
      s1_addr  = {s1_chan_ff, s1_note_ff};
      is_on    = (s1_kind_ff == KIND_NOTE_ON);
      is_off   = (s1_kind_ff == KIND_NOTE_OFF);
      is_start = (s1_kind_ff == KIND_TRACK_START);
      hit      = s1_go && is_off && s1_live;
      wrap     = s1_valid_ff && is_start && (epoch_ff == {EPOCH_W{1'b1}});

      s1_wr.en                 = s1_go && (is_on || (is_off && s1_live));
      s1_wr.addr               = s1_addr;
      s1_wr.data.valid         = is_on;
      s1_wr.data.epoch         = epoch_ff;
      s1_wr.data.velocity      = s1_vel_ff;
      s1_wr.data.on_tick       = s1_tick_ff;

      req_tready = !clr_ff && !wrap && (!s1_valid_ff || out_free);
   end

   // table write: clearing sweep or item update
   always_comb begin
      if (clr_ff) begin
         ram_wr.en   = 1'b1;
         ram_wr.addr = clr_addr_ff;
         ram_wr.data = '0;
      end else begin
         ram_wr = s1_wr;
      end
   end

   // next-state of control registers
   always_comb begin
      fwd_hit_in = accept && s1_wr.en && (s1_wr.addr == req_addr);

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      epoch_in = epoch_ff;
      if (s1_go && is_start) begin
         epoch_in = epoch_ff + 1'b1;
      end

      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end else if (s1_go && wrap) begin
         clr_in      = 1'b1;
         clr_addr_in = '0;
      end

      if (hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         epoch_ff     <= '0;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         if (accept) begin
            fwd_hit_ff <= fwd_hit_in;
         end
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // work stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= req_tuser;
         s1_track_ff <= req_track;
         s1_chan_ff  <= req_channel;
         s1_note_ff  <= req_note;
         s1_vel_ff   <= req_velocity;
         s1_tick_ff  <= req_tick;
         fwd_data_ff <= s1_wr.data;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (hit) begin
         rsp_data_ff <= {s1_tick_ff, s1_entry.on_tick, s1_entry.velocity,
                         s1_note_ff, s1_chan_ff, s1_track_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/mnpt_checker.sv
// Port-level checks for the MIDI note pair tracker, bound to the top level.
module mnpt_checker
   import mnpt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // table clearing keeps the input closed right after reset
   assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("input open during table clear");

   // a fresh result comes from an earlier accepted note-off
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         $past(req_tvalid && req_tready && (req_tuser == KIND_NOTE_OFF), 2))
      else $error("result without matching note-off");

   // that result carries the note-off's tick, channel and note
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         (rsp_tdata[95:65] == $past(req_tdata[64:34], 2)) &&
         (rsp_tdata[26:16] == $past(req_tdata[26:16], 2)))
      else $error("result fields do not match note-off");

endmodule

bind midi_note_pair_tracker_core mnpt_checker u_mnpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
